>>> sv/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ssd_pkg.sv
package ssd_pkg;

	localparam int BYTE_W   = 8;
	localparam int PHASE_W  = 3;
	localparam int CFG_IDX_W = 8;
	localparam int OUT_DATA_W = 24;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'd19;

	localparam logic [BYTE_W-1:0] RST_EXPECTED_ID    = 8'd100;
	localparam logic [BYTE_W-1:0] RST_PAYLOAD_LENGTH = 8'd80;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 8'd1;

	localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ID      = 3'd2;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd4;

	typedef struct packed {
		logic              is_payload;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_offset;
		logic              frame_done;
		logic              checksum_ok;
	} ssd_res_t;

	typedef struct packed {
		logic [BYTE_W-1:0] expected_id;
		logic [BYTE_W-1:0] payload_length;
	} ssd_cfg_t;

endpackage

>>> sv/sensor_stream_deframer.sv
// Sensor stream deframer.
// Input stream (s_*): one received serial byte per beat on s_tdata[7:0].
// The block hunts for header 19, length byte (payload length + 1), packet id,
// payload, checksum. Header, length and id bytes give no output; a byte that
// fails a check is dropped and the hunt restarts with the next byte.
// Output stream (m_*): one beat per payload byte (m_tuser = 1, byte and its
// offset in m_tdata) and one verdict beat after the checksum byte
// (m_tlast = 1, m_tdata[16] = frame sums to zero modulo 256).
// Config channel (cfg_*): index 0 = expected id, 1 = payload length; always
// ready; the user must write it only while the block is idle, the block does not enforce this.
// Pipeline: an accepted byte loads the input register, and its result then loads
// the result register. Throughput: one byte per cycle while no byte with a result
// waits on a stalled output; the parse state updates once per byte.
// Reset: parser hunts for a header, registers return to id 100, length 80,
// both pipeline stages empty.
// Output stall: the result register holds; the input register keeps taking
// bytes that produce no output, and s_tready drops once a byte with a result
// waits behind a full, stalled result register.
module sensor_stream_deframer
	import ssd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_offset,
	                                         // [16] checksum_ok, [23:17] zero
	output logic                  m_tuser,   // [0] is_payload
	output logic                  m_tlast,   // frame_done
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_data
);

`include "assert_macros.svh"

	ssd_cfg_t          cfg;
	ssd_res_t          res;
	ssd_res_t          res_q;
	logic              has_result;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              advance;
	logic              s_accept;

	assign cfg_ready = 1'b1;

	ssd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ssd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.byte_s1    (byte_s1),
		.advance    (advance),
		.has_result (has_result),
		.res        (res)
	);

	assign advance  = valid_s1 & (~has_result | ~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign s_accept = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.is_payload;
	assign m_tlast  = res_q.frame_done;
	assign m_tdata  = {7'd0, res_q.checksum_ok, res_q.payload_offset, res_q.payload_byte};

	`ASSERT_CLK(a_verdict_not_payload, !(m_tvalid && m_tlast && m_tuser),
		"verdict beat marked as payload")
	`ASSERT_CLK(a_payload_no_ok, !(m_tvalid && m_tuser && m_tdata[16]),
		"payload beat carries checksum flag")
	`ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(byte_s1),
		"stalled input stage lost its byte")

endmodule

>>> sv/ssd_cfg.sv
module ssd_cfg
	import ssd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [BYTE_W-1:0]    wr_data,
	output ssd_cfg_t             cfg
);

	ssd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_id    <= RST_EXPECTED_ID;
			cfg_q.payload_length <= RST_PAYLOAD_LENGTH;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EXPECTED_ID:    cfg_q.expected_id    <= wr_data;
				REG_PAYLOAD_LENGTH: cfg_q.payload_length <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/ssd_parse.sv
module ssd_parse
	import ssd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ssd_cfg_t          cfg,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic              advance,
	output logic              has_result,
	output ssd_res_t          res
);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [BYTE_W-1:0]  count_q, count_d;
	logic [BYTE_W-1:0]  sum_q, sum_d;
	logic [BYTE_W-1:0]  sum_next;
	logic [BYTE_W-1:0]  count_inc;
	logic [BYTE_W:0]    len_plus1;
	logic               sum_zero;

	assign sum_next  = sum_q + byte_s1;
	assign count_inc = count_q + 8'd1;
	assign len_plus1 = {1'b0, cfg.payload_length} + 9'd1;
	assign sum_zero  = (sum_next == '0);

	always_comb begin
		phase_d    = PH_HEADER;
		count_d    = '0;
		sum_d      = '0;
		has_result = 1'b0;
		res        = '0;
		unique case (phase_q)
			PH_LENGTH: begin
				if ({1'b0, byte_s1} == len_plus1) begin
					phase_d = PH_ID;
					count_d = count_q;
					sum_d   = sum_next;
				end
			end
			PH_ID: begin
				if (byte_s1 == cfg.expected_id) begin
					phase_d = (cfg.payload_length == '0) ? PH_CHECK : PH_PAYLOAD;
					sum_d   = sum_next;
				end
			end
			PH_PAYLOAD: begin
				has_result = 1'b1;
				if (count_q < cfg.payload_length) begin
					res.is_payload     = 1'b1;
					res.payload_byte   = byte_s1;
					res.payload_offset = count_q;
					sum_d   = sum_next;
					count_d = count_inc;
					phase_d = (count_inc >= cfg.payload_length) ? PH_CHECK : PH_PAYLOAD;
				end else begin
					// length lowered mid-frame: this byte is the checksum
					res.frame_done  = 1'b1;
					res.checksum_ok = sum_zero;
				end
			end
			PH_CHECK: begin
				has_result      = 1'b1;
				res.frame_done  = 1'b1;
				res.checksum_ok = sum_zero;
			end
			default: begin
				// unused codes hunt for a header too
				if (byte_s1 == HDR_BYTE) begin
					phase_d = PH_LENGTH;
					sum_d   = byte_s1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= '0;
			sum_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

endmodule

>>> tb/tb.sv
module tb
	import ssd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 1000;

	logic clk;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata = '0;      // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;           // [7:0] payload_byte, [15:8] payload_offset,
	                                          // [16] checksum_ok
	logic                  m_tuser;           // [0] is_payload
	logic                  m_tlast;           // frame_done
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [BYTE_W-1:0]     cfg_data = '0;

	sensor_stream_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// parser mirror, registers read live like the block does
	logic [BYTE_W-1:0]  cfg_id     = RST_EXPECTED_ID;
	logic [BYTE_W-1:0]  cfg_len    = RST_PAYLOAD_LENGTH;
	logic [PHASE_W-1:0] hunt_phase = PH_HEADER;
	logic [BYTE_W-1:0]  pay_cnt    = '0;
	logic [BYTE_W-1:0]  frame_sum  = '0;

	ssd_res_t          frame_out_q[$];
	logic [BYTE_W-1:0] rx_bytes[$];

	int  errors      = 0;
	int  phase_bytes = 0;
	int  tx_gap      = 0;
	int  rx_stall    = 0;
	int  idle_cycles = 0;
	bit  calm        = 1'b0;

	function automatic void restart_hunt();
		hunt_phase = PH_HEADER;
		pay_cnt    = '0;
		frame_sum  = '0;
	endfunction

	function automatic void push_verdict(input logic [BYTE_W-1:0] sum);
		ssd_res_t r;
		r = '0;
		r.frame_done  = 1'b1;
		r.checksum_ok = (sum == 8'd0);
		frame_out_q.push_back(r);
		restart_hunt();
	endfunction

	function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
		ssd_res_t          r;
		logic [BYTE_W-1:0] sum;
		sum = frame_sum + b;
		r   = '0;
		case (hunt_phase)
			PH_LENGTH: begin
				// 9-bit compare: length 255 can never match
				if ({1'b0, b} == 9'(cfg_len) + 9'd1) begin
					frame_sum  = sum;
					hunt_phase = PH_ID;
				end else
					restart_hunt();
			end
			PH_ID: begin
				if (b == cfg_id) begin
					frame_sum  = sum;
					pay_cnt    = '0;
					hunt_phase = (cfg_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end else
					restart_hunt();
			end
			PH_PAYLOAD: begin
				if (pay_cnt < cfg_len) begin
					r.is_payload     = 1'b1;
					r.payload_byte   = b;
					r.payload_offset = pay_cnt;
					frame_out_q.push_back(r);
					frame_sum = sum;
					pay_cnt   = pay_cnt + 8'd1;
					if (pay_cnt >= cfg_len)
						hunt_phase = PH_CHECK;
				end else
					push_verdict(sum);  // length lowered under the count: checksum byte
			end
			PH_CHECK:
				push_verdict(sum);
			default: begin
				if (b == HDR_BYTE) begin
					frame_sum  = b;
					pay_cnt    = '0;
					hunt_phase = PH_LENGTH;
				end else
					restart_hunt();
			end
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function automatic void send_byte(input logic [BYTE_W-1:0] b);
		rx_bytes.push_back(b);
		phase_bytes++;
	endfunction

	function automatic void queue_frame(input bit good_sum);
		logic [BYTE_W-1:0] s;
		logic [BYTE_W-1:0] p;
		s = HDR_BYTE + (cfg_len + 8'd1) + cfg_id;
		send_byte(HDR_BYTE);
		send_byte(cfg_len + 8'd1);
		send_byte(cfg_id);
		for (int i = 0; i < int'(cfg_len); i++) begin
			p = 8'($urandom);
			s = s + p;
			send_byte(p);
		end
		send_byte(good_sum ? (~s + 8'd1) : 8'($urandom));
	endfunction

	function automatic void queue_broken();
		int k;
		int n;
		k = $urandom_range(0, 3);
		send_byte(HDR_BYTE);
		case (k)
			0: send_byte(cfg_len + 8'd1 + 8'($urandom_range(1, 255)));
			1: begin
				send_byte(cfg_len + 8'd1);
				send_byte(cfg_id ^ 8'($urandom_range(1, 255)));
			end
			2: begin
				// cut short: the stream that follows lands inside this frame
				send_byte(cfg_len + 8'd1);
				send_byte(cfg_id);
				n = $urandom_range(0, (cfg_len > 8'd20) ? 20 : int'(cfg_len));
				repeat (n) send_byte(8'($urandom));
			end
			default: send_byte(HDR_BYTE);
		endcase
	endfunction

	function automatic void queue_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) send_byte(($urandom_range(0, 9) == 0) ? HDR_BYTE : 8'($urandom));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range(1, 6));
		if (r < 90)
			return 8'($urandom_range(7, 40));
		return 8'($urandom_range(41, 253));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_EXPECTED_ID:    cfg_id  = val;
			REG_PAYLOAD_LENGTH: cfg_len = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// all bytes in, all results out, then room for a byte still in the pipe
	task automatic wait_idle();
		do @(negedge clk); while (rx_bytes.size() != 0 || s_tvalid || frame_out_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				if (!calm && $urandom_range(0, 99) < 30)
					tx_gap = gap_len();
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (rx_bytes.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= rx_bytes.pop_front();
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (frame_out_q.size() == 0) begin
					$error("result beat with nothing expected: tdata=%h tuser=%b tlast=%b",
						m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					check_field("is_payload", 8'(frame_out_q[0].is_payload), 8'(m_tuser));
					check_field("payload_byte", frame_out_q[0].payload_byte, m_tdata[7:0]);
					check_field("payload_offset", frame_out_q[0].payload_offset, m_tdata[15:8]);
					check_field("frame_done", 8'(frame_out_q[0].frame_done), 8'(m_tlast));
					check_field("checksum_ok", 8'(frame_out_q[0].checksum_ok), 8'(m_tdata[16]));
					void'(frame_out_q.pop_front());
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 20) begin
				rx_stall = gap_len() - 1;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int                 r;
		logic [BYTE_W-1:0]  new_id;
		logic [BYTE_W-1:0]  new_len;
		logic [CFG_IDX_W-1:0] spare_idx;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers; a repeated header is eaten as a bad length byte
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(RST_PAYLOAD_LENGTH + 8'd1);
		send_byte(RST_EXPECTED_ID);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(8'h01);
		wait_idle();
		// length drops below the payload count mid-frame: next byte closes it
		write_reg(REG_PAYLOAD_LENGTH, 8'd2);
		send_byte(8'h80);
		wait_idle();
		// empty payload, checksum right after the id
		write_reg(REG_EXPECTED_ID, 8'hFF);
		write_reg(REG_PAYLOAD_LENGTH, 8'd0);
		queue_frame(1'b1);
		queue_frame(1'b0);
		send_byte(HDR_BYTE);
		send_byte(8'd1);
		send_byte(8'hFE);
		wait_idle();
		// length 255 can never be matched
		write_reg(REG_PAYLOAD_LENGTH, 8'd255);
		send_byte(HDR_BYTE);
		send_byte(8'h00);
		send_byte(HDR_BYTE);
		send_byte(8'hFF);

		for (int ph = 0; ph < 13; ph++) begin
			wait_idle();
			calm = ($urandom_range(0, 3) == 0);
			new_id = 8'($urandom);
			case (ph)
				2: begin
					new_id  = 8'h00;
					new_len = 8'd254;
				end
				5: new_len = 8'd0;
				8: new_len = 8'd255;
				10: new_len = RST_PAYLOAD_LENGTH;
				default: new_len = pick_len();
			endcase
			if (ph == 2 || $urandom_range(0, 3) != 0)
				write_reg(REG_EXPECTED_ID, new_id);
			write_reg(REG_PAYLOAD_LENGTH, new_len);
			if ($urandom_range(0, 6) == 0) begin
				spare_idx = 8'($urandom_range(2, 255));
				write_reg(spare_idx, 8'($urandom));
			end
			phase_bytes = 0;
			while (phase_bytes < 75) begin
				r = $urandom_range(0, 99);
				if (cfg_len != 8'd255 && r < 70)
					queue_frame($urandom_range(0, 4) != 0);
				else if (r < 85)
					queue_broken();
				else
					queue_noise();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (frame_out_q.size() != 0) begin
			$error("%0d expected results never arrived", frame_out_q.size());
			errors++;
		end
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sensor_stream_deframer.f
+incdir+sv
sv/ssd_pkg.sv
sv/ssd_cfg.sv
sv/ssd_parse.sv
sv/sensor_stream_deframer.sv
tb/tb.sv
